// File: rtl/core/cic_pkg.sv
// ----------------------------------------------------------------------------
// cic_pkg
// Shared types and constants for the controller input capture block.
// ----------------------------------------------------------------------------
package cic_pkg;

   // item opcodes
   localparam logic [1:0] OP_EVENT = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;

   // event types
   localparam logic [1:0] EV_KEY  = 2'd0;
   localparam logic [1:0] EV_AXIS = 2'd1;

   // capture modes
   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_BUTTON = 2'd1;
   localparam logic [1:0] MODE_STICK  = 2'd2;

   // report kinds
   localparam logic [1:0] KIND_BUTTON = 2'd0;
   localparam logic [1:0] KIND_AXIS   = 2'd1;
   localparam logic [1:0] KIND_PAIR   = 2'd2;

   // register indexes
   localparam logic CSR_MODE    = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;

   localparam int unsigned IDLE_W = 20;
   localparam logic [IDLE_W-1:0] IDLE_MAX      = '1;
   localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 20'd30000;

   // one accepted input item
   typedef struct packed {
      logic [1:0]         opcode;
      logic [1:0]         event_type;
      logic [15:0]        event_code;
      logic signed [31:0] event_value;
   } item_type;

   // axis table row
   typedef struct packed {
      logic signed [31:0] low;
      logic signed [31:0] high;
      logic signed [31:0] neutral;
   } axis_row_type;

   // deflection test result
   typedef struct packed {
      logic past_limit;
      logic negative;
   } deflect_type;

endpackage

// File: rtl/core/cic_ram.sv
// ----------------------------------------------------------------------------
// cic_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module cic_ram #(
   parameter int unsigned WIDTH = 96,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/core/cic_deflect.sv
// ----------------------------------------------------------------------------
// cic_deflect
// Tests whether an axis position has moved at least 35% of the span from rest.
// ----------------------------------------------------------------------------
module cic_deflect (
   input  logic signed [31:0]   position,
   input  cic_pkg::axis_row_type row,
   output cic_pkg::deflect_type result
);

   logic signed [32:0] span;
   logic signed [32:0] moved;
   logic [32:0]        distance;
   logic [37:0]        dist_x20;
   logic [37:0]        span_x7;

   // span and distance from rest, one bit wider than the operands
   assign span     = 33'(row.high) - 33'(row.low);
   assign moved    = 33'(position) - 33'(row.neutral);
   assign distance = moved[32] ? 33'(-moved) : 33'(moved);

   // 20*distance >= 7*span, constant multiplies as shift and add or subtract
   assign dist_x20 = (38'(distance) << 4) + (38'(distance) << 2);
   assign span_x7  = (38'(span[31:0]) << 3) - 38'(span[31:0]);

   assign result.negative   = moved[32];
   assign result.past_limit = !span[32] && (span != '0) && (dist_x20 >= span_x7);

endmodule

// File: rtl/core/controller_input_capture.sv
// ----------------------------------------------------------------------------
// controller_input_capture
// Learn-mode capture for a gamepad: button presses, axes as buttons, stick pairs.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | tvalid/tready      | tuser opcode, tdata event and axis table load
//  rsp     | out | tvalid/tready      | tuser report kind, tdata flags and report
//  csr     | in  | wr_en, no stall    | index, 20-bit write data
//
//  The axis table RAM read is registered with the item in the item stage, then one
//  pass of compare and state update loads the rsp register.
//  One item per cycle is sustained; req_tready drops only while both the item stage
//  and the rsp register are full and rsp_tready is low.
//  Synchronous active high reset clears mode, capture state and axis present bits,
//  sets timeout to 30000; the axis table RAM has no reset and no clearing pass.
// ----------------------------------------------------------------------------
module controller_input_capture #(
   parameter int unsigned AXIS_COUNT = 64
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // opcode
   input  logic [151:0] req_tdata,   // event_type, event_code, event_value, axis_present,
                                     // axis_minimum, axis_maximum, axis_rest, zero fill
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,   // report_kind
   output logic [31:0]  rsp_tdata,   // swallowed, report_valid, report_code,
                                     // report_first_axis, report_negative,
                                     // report_first_negative, expired, zero fill
   // configuration port
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [19:0]  csr_wr_data
);

   localparam int unsigned IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int unsigned IW    = cic_pkg::IDLE_W;

   // request fields
   cic_pkg::item_type     req_item;
   logic                  req_present;
   cic_pkg::axis_row_type req_row;
   logic                  req_accept;
   logic                  req_in_range;
   logic [IDX_W-1:0]      req_idx;

   assign req_item.opcode      = req_tuser;
   assign req_item.event_type  = req_tdata[1:0];
   assign req_item.event_code  = req_tdata[17:2];
   assign req_item.event_value = req_tdata[49:18];
   assign req_present          = req_tdata[50];
   assign req_row.low          = req_tdata[82:51];
   assign req_row.high         = req_tdata[114:83];
   assign req_row.neutral      = req_tdata[146:115];

   assign req_accept   = req_tvalid && req_tready;
   assign req_in_range = req_item.event_code < 16'(AXIS_COUNT);
   assign req_idx      = req_item.event_code[IDX_W-1:0];

   // configuration and capture state
   logic [1:0]       mode_ff;
   logic [IW-1:0]    timeout_ff;
   logic             latched_ff,   latched_in;
   logic             first_ff,     first_in;
   logic [IDX_W-1:0] first_idx_ff, first_idx_in;
   logic             first_neg_ff, first_neg_in;
   logic [IW-1:0]    idle_ff,      idle_in;
   logic [AXIS_COUNT-1:0] exists_ff;

   // item stage and response register
   logic              s1_valid_ff;
   cic_pkg::item_type s1_ff;
   logic              s1_fire;
   logic              out_free;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   // axis table, read at every req transfer and written at an in-range load transfer
   logic                  tbl_wr;
   logic [95:0]           tbl_rd;
   cic_pkg::axis_row_type s1_row;

   assign tbl_wr = req_accept && (req_item.opcode == cic_pkg::OP_LOAD) && req_in_range;
   assign s1_row = cic_pkg::axis_row_type'(tbl_rd);

   cic_ram #(
      .WIDTH (96),
      .DEPTH (AXIS_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (req_idx),
      .wr_data (96'(req_row)),
      .rd_en   (req_accept),
      .rd_addr (req_idx),
      .rd_data (tbl_rd)
   );

   // deflection test on the staged event
   cic_pkg::deflect_type defl;

   cic_deflect u_deflect (
      .position (s1_ff.event_value),
      .row      (s1_row),
      .result   (defl)
   );

   // item stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_accept) begin
         s1_ff <= req_item;
      end
   end

   // axis present bits
   always_ff @(posedge clock) begin
      if (reset) begin
         exists_ff <= '0;
      end else if (tbl_wr) begin
         exists_ff[req_idx] <= req_present;
      end
   end

   // capture decision for the staged item
   logic             active;
   logic             s1_in_range;
   logic             s1_axis_ok;
   logic [IDX_W-1:0] s1_idx;
   logic             swallowed;
   logic             rep_valid;
   logic [15:0]      rep_code;
   logic [5:0]       rep_first;
   logic             rep_neg;
   logic             rep_fneg;
   logic             expired;

   assign active      = (mode_ff == cic_pkg::MODE_BUTTON) || (mode_ff == cic_pkg::MODE_STICK);
   assign s1_idx      = s1_ff.event_code[IDX_W-1:0];
   assign s1_in_range = s1_ff.event_code < 16'(AXIS_COUNT);
   assign s1_axis_ok  = s1_in_range && exists_ff[s1_idx] && defl.past_limit;

   always_comb begin
      latched_in   = latched_ff;
      first_in     = first_ff;
      first_idx_in = first_idx_ff;
      first_neg_in = first_neg_ff;
      idle_in      = idle_ff;
      swallowed    = 1'b0;
      rep_valid    = 1'b0;
      rsp_kind_in  = cic_pkg::KIND_BUTTON;
      rep_code     = '0;
      rep_first    = '0;
      rep_neg      = 1'b0;
      rep_fneg     = 1'b0;
      case (s1_ff.opcode)
         cic_pkg::OP_TICK: begin
            if (idle_ff != cic_pkg::IDLE_MAX) begin
               idle_in = idle_ff + 1'b1;
            end
         end
         cic_pkg::OP_EVENT: begin
            if (active) begin
               swallowed = 1'b1;
               if (!latched_ff && s1_ff.event_type == cic_pkg::EV_KEY) begin
                  if (s1_ff.event_value == 32'sd1) begin
                     rep_valid  = 1'b1;
                     rep_code   = s1_ff.event_code;
                     latched_in = 1'b1;
                  end
               end else if (!latched_ff && s1_ff.event_type == cic_pkg::EV_AXIS
                            && s1_axis_ok) begin
                  if (mode_ff == cic_pkg::MODE_BUTTON) begin
                     rep_valid   = 1'b1;
                     rsp_kind_in = cic_pkg::KIND_AXIS;
                     rep_code    = s1_ff.event_code;
                     rep_neg     = defl.negative;
                     latched_in  = 1'b1;
                  end else if (!first_ff) begin
                     first_in     = 1'b1;
                     first_idx_in = s1_idx;
                     first_neg_in = defl.negative;
                  end else if (first_idx_ff != s1_idx) begin
                     rep_valid   = 1'b1;
                     rsp_kind_in = cic_pkg::KIND_PAIR;
                     rep_code    = s1_ff.event_code;
                     rep_first   = 6'(first_idx_ff);
                     rep_neg     = defl.negative;
                     rep_fneg    = first_neg_ff;
                     latched_in  = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      expired     = active && (idle_in >= timeout_ff);
      rsp_data_in = {5'd0, expired, rep_fneg, rep_neg, rep_first, rep_code,
                     rep_valid, swallowed};
   end

   // registers and capture state; a mode write restarts capture
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= cic_pkg::MODE_OFF;
         timeout_ff   <= cic_pkg::TIMEOUT_RESET;
         latched_ff   <= 1'b0;
         first_ff     <= 1'b0;
         first_idx_ff <= '0;
         first_neg_ff <= 1'b0;
         idle_ff      <= '0;
      end else if (csr_wr_en && csr_index == cic_pkg::CSR_MODE) begin
         mode_ff      <= csr_wr_data[1:0];
         latched_ff   <= 1'b0;
         first_ff     <= 1'b0;
         first_idx_ff <= '0;
         first_neg_ff <= 1'b0;
         idle_ff      <= '0;
      end else begin
         if (csr_wr_en && csr_index == cic_pkg::CSR_TIMEOUT) begin
            timeout_ff <= csr_wr_data;
         end
         if (s1_fire) begin
            latched_ff   <= latched_in;
            first_ff     <= first_in;
            first_idx_ff <= first_idx_in;
            first_neg_ff <= first_neg_in;
            idle_ff      <= idle_in;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_fire) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/core/cic_checker.sv
// ----------------------------------------------------------------------------
// cic_checker
// Port-level checks on the capture responses, bound to the top level.
// ----------------------------------------------------------------------------
module cic_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic [31:0] rsp_tdata
);

   // nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // a report only comes from a swallowed event
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("report without swallow");

   // without a report all report fields are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |->
         rsp_tuser == cic_pkg::KIND_BUTTON && rsp_tdata[25:2] == 24'd0)
      else $error("report fields set without report");

   // first axis fields only in pair reports
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != cic_pkg::KIND_PAIR |->
         rsp_tdata[23:18] == 6'd0 && !rsp_tdata[25])
      else $error("first axis fields outside a pair report");

endmodule

bind controller_input_capture cic_checker u_cic_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
